>>> sv/rom_page_translation_round_robin_core_defines.svh
// Assertion macros used by the port-level checker of the ROM page translation core.
`ifndef ROM_PAGE_TRANSLATION_ROUND_ROBIN_CORE_DEFINES_SVH
`define ROM_PAGE_TRANSLATION_ROUND_ROBIN_CORE_DEFINES_SVH

// same-cycle implication
`define RPTRR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RPTRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rptrr_pkg.sv
// Package: field widths, stream packing offsets, result type and open-bus function.
package rptrr_pkg;

    localparam int ADDR_W      = 25;
    localparam int TYPE_W      = 2;
    localparam int ROM_SIZE_W  = 26;
    localparam int OBV_W       = 32;
    localparam int PAGE_OUT_W  = 11;
    localparam int FRAME_OUT_W = 8;
    localparam int PHYS_W      = 22;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 88;

    localparam int OFS_FILL_REQ  = OBV_W;
    localparam int OFS_FILL_PAGE = OFS_FILL_REQ + 1;
    localparam int OFS_FRAME     = OFS_FILL_PAGE + PAGE_OUT_W;
    localparam int OFS_PHYS      = OFS_FRAME + FRAME_OUT_W;
    localparam int OFS_EV_VALID  = OFS_PHYS + PHYS_W;
    localparam int OFS_EV_PAGE   = OFS_EV_VALID + 1;
    localparam int RES_W         = OFS_EV_PAGE + PAGE_OUT_W;

    typedef logic [TYPE_W-1:0] t_req_type;
    localparam t_req_type REQ_BYTE = 2'd0;
    localparam t_req_type REQ_HALF = 2'd1;
    localparam t_req_type REQ_WORD = 2'd2;

    // first member is the top field in tdata
    typedef struct packed {
        logic [PAGE_OUT_W-1:0]  ev_page;
        logic                   ev_valid;
        logic [PHYS_W-1:0]      phys_addr;
        logic [FRAME_OUT_W-1:0] frame;
        logic [PAGE_OUT_W-1:0]  fill_page;
        logic                   fill_request;
        logic [OBV_W-1:0]       open_bus_value;
    } t_result;

    function automatic logic [OBV_W-1:0] open_bus(input t_req_type t,
                                                  input logic [ADDR_W-1:0] a);
        logic [ADDR_W:0] a2;
        logic [OBV_W-1:0] v;
        a2 = {1'b0, a} + (ADDR_W+1)'(2);
        case (t)
            REQ_BYTE: v = {24'b0, a[8:1]};
            REQ_HALF: v = {16'b0, a[16:1]};
            REQ_WORD: v = {a[16:1], a2[16:1]};
            default:  v = {a[16:1], a2[16:1]};
        endcase
        return v;
    endfunction

endpackage

>>> sv/rptrr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rptrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/rom_page_translation_round_robin_core.sv
// Top level: demand-paged ROM window translator with round-robin frame replacement.
//
//  channel   | dir | tdata / data              | tuser
//  s_axis    | in  | address                   | req_type
//  m_axis    | out | open_bus_value, fill_request, fill_page, frame,
//            |     | phys_addr, evicted_valid, evicted_page | in_range
//  cfg       | in  | rom_size                  | -
//
// Hits and open-bus requests end after the page table read; misses then also read the owner table.
// After reset a clearing pass steps through max(VIRT_PAGES, FRAMES) indices writing both tables
// (2048 by default); s_axis_tready is low until it ends, cfg writes are taken throughout.
// A result waiting in the output register stalls the core only when the next one is done.
// VIRT_PAGES is a power of two.
module rom_page_translation_round_robin_core
    import rptrr_pkg::*;
#(
    parameter int PAGE_BITS  = 14,
    parameter int VIRT_PAGES = 2048,
    parameter int FRAMES     = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,  // address
    input  logic [TYPE_W-1:0]     s_axis_tuser,  // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // open_bus_value, fill_request, fill_page, frame, phys_addr, evicted_valid, evicted_page
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    output logic [0:0]            m_axis_tuser,  // in_range
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [ROM_SIZE_W-1:0] i_cfg_data
);

    localparam int PG_W      = $clog2(VIRT_PAGES);
    localparam int FR_W      = $clog2(FRAMES);
    localparam int PM_W      = FR_W + 1;
    localparam int OWN_W     = PG_W + 1;
    localparam int CLR_DEPTH = (VIRT_PAGES > FRAMES) ? VIRT_PAGES : FRAMES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_EVICT} t_state;

    t_state                r_state;
    logic [CLR_W-1:0]      r_clr_idx;
    logic [FR_W-1:0]       r_next;
    logic [FR_W-1:0]       r_new;
    logic [ROM_SIZE_W-1:0] r_rom_size;
    t_req_type             r_type;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_in_range;
    logic [PG_W-1:0]       r_page;
    logic                  r_m_valid;
    logic [M_DATA_W-1:0]   r_m_data;
    logic                  r_m_user;

    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] in_page_sh;
    logic [PG_W-1:0]   in_page;
    logic              accept;
    logic              slot_free;
    logic              res_load;
    logic [FR_W-1:0]   n_frame;

    logic              pm_wr_en, pm_rd_en;
    logic [PG_W-1:0]   pm_wr_addr;
    logic [PM_W-1:0]   pm_wr_data, pm_rd_data;
    logic              own_wr_en, own_rd_en;
    logic [FR_W-1:0]   own_wr_addr;
    logic [OWN_W-1:0]  own_wr_data, own_rd_data;

    logic                 pm_hit;
    logic [FR_W-1:0]      res_fr;
    logic [FR_W+PAGE_BITS-1:0] phys_full;
    logic [63:0]          phys_wide, fr_wide, page_wide, old_wide;
    t_result              res;

    assign in_addr    = s_axis_tdata[ADDR_W-1:0];
    assign in_page_sh = in_addr >> PAGE_BITS;
    assign in_page    = in_page_sh[PG_W-1:0];
    assign accept     = (r_state == ST_IDLE) && s_axis_tvalid;
    assign slot_free  = !r_m_valid || m_axis_tready;
    assign n_frame    = (r_next == FR_W'(FRAMES - 1)) ? FR_W'(1) : r_next + FR_W'(1);
    assign pm_hit     = pm_rd_data[PM_W-1];
    assign res_load   = slot_free && ((r_state == ST_EVICT)
                        || ((r_state == ST_LOOK) && !(r_in_range && !pm_hit)));

    // table access control
    always_comb begin
        pm_wr_en    = 1'b0;
        pm_wr_addr  = r_page;
        pm_wr_data  = '0;
        own_wr_en   = 1'b0;
        own_wr_addr = r_new;
        own_wr_data = {1'b1, r_page};
        case (r_state)
            ST_CLEAR: begin
                pm_wr_en    = 32'(r_clr_idx) < VIRT_PAGES;
                pm_wr_addr  = r_clr_idx[PG_W-1:0];
                pm_wr_data  = (r_clr_idx == '0) ? {1'b1, {FR_W{1'b0}}} : '0;
                own_wr_en   = 32'(r_clr_idx) < FRAMES;
                own_wr_addr = r_clr_idx[FR_W-1:0];
                own_wr_data = (r_clr_idx == '0) ? {1'b1, {PG_W{1'b0}}} : '0;
            end
            ST_LOOK: begin
                pm_wr_en   = r_in_range && !pm_hit;
                pm_wr_addr = r_page;
                pm_wr_data = {1'b1, n_frame};
            end
            ST_EVICT: begin
                pm_wr_en   = slot_free && own_rd_data[OWN_W-1];
                pm_wr_addr = own_rd_data[PG_W-1:0];
                pm_wr_data = '0;
                own_wr_en  = slot_free;
            end
            default: begin
            end
        endcase
    end

    assign pm_rd_en  = accept;
    assign own_rd_en = (r_state == ST_LOOK) && r_in_range && !pm_hit;

    // result assembly
    always_comb begin
        res    = '0;
        res_fr = (r_state == ST_EVICT) ? r_new : pm_rd_data[FR_W-1:0];
        phys_full = {res_fr, r_addr[PAGE_BITS-1:0]};
        phys_wide = 64'(phys_full);
        fr_wide   = 64'(res_fr);
        page_wide = 64'(r_page);
        old_wide  = 64'(own_rd_data[PG_W-1:0]);
        if (!r_in_range) begin
            res.open_bus_value = open_bus(r_type, r_addr);
        end else begin
            res.frame     = fr_wide[FRAME_OUT_W-1:0];
            res.phys_addr = phys_wide[PHYS_W-1:0];
            if (r_state == ST_EVICT) begin
                res.fill_request = 1'b1;
                res.fill_page    = page_wide[PAGE_OUT_W-1:0];
                res.ev_valid     = own_rd_data[OWN_W-1];
                res.ev_page      = own_rd_data[OWN_W-1] ? old_wide[PAGE_OUT_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_idx  <= '0;
            r_next     <= '0;
            r_rom_size <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rom_size <= i_cfg_data;
            end
            if (res_load) begin
                r_m_valid <= 1'b1;
                r_m_data  <= M_DATA_W'(res);
                r_m_user  <= r_in_range;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + CLR_W'(1);
                    if (r_clr_idx == CLR_W'(CLR_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_type     <= s_axis_tuser;
                        r_addr     <= in_addr;
                        r_in_range <= {1'b0, in_addr} < r_rom_size;
                        r_page     <= in_page;
                        r_state    <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (r_in_range && !pm_hit) begin
                        r_next  <= n_frame;
                        r_new   <= n_frame;
                        r_state <= ST_EVICT;
                    end else if (slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EVICT: begin
                    if (slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    rptrr_ram #(
        .WIDTH(PM_W),
        .DEPTH(VIRT_PAGES)
    ) u_page_map (
        .i_clk    (i_clk),
        .i_wr_en  (pm_wr_en),
        .i_wr_addr(pm_wr_addr),
        .i_wr_data(pm_wr_data),
        .i_rd_en  (pm_rd_en),
        .i_rd_addr(in_page),
        .o_rd_data(pm_rd_data)
    );

    rptrr_ram #(
        .WIDTH(OWN_W),
        .DEPTH(FRAMES)
    ) u_frame_owner (
        .i_clk    (i_clk),
        .i_wr_en  (own_wr_en),
        .i_wr_addr(own_wr_addr),
        .i_wr_data(own_wr_data),
        .i_rd_en  (own_rd_en),
        .i_rd_addr(n_frame),
        .o_rd_data(own_rd_data)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign o_cfg_ready   = 1'b1;

endmodule

>>> sv/rptrr_checker.sv
// Port-level checker for the ROM page translation core, bound to the top level.
`include "rom_page_translation_round_robin_core_defines.svh"

module rptrr_checker
    import rptrr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [0:0]          m_axis_tuser
);

    logic fill_req, ev_valid;
    logic [PAGE_OUT_W-1:0]  fill_page, ev_page;
    logic [FRAME_OUT_W-1:0] frame;

    assign fill_req  = m_axis_tdata[OFS_FILL_REQ];
    assign ev_valid  = m_axis_tdata[OFS_EV_VALID];
    assign fill_page = m_axis_tdata[OFS_FRAME-1:OFS_FILL_PAGE];
    assign ev_page   = m_axis_tdata[RES_W-1:OFS_EV_PAGE];
    assign frame     = m_axis_tdata[OFS_PHYS-1:OFS_FRAME];

    // open-bus results carry nothing but the open-bus value
    `RPTRR_ASSERT_IMPLY(a_open_bus_clean, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[M_DATA_W-1:OFS_FILL_REQ] == '0, "open-bus result with translation fields set")

    // mapped results: no open-bus value, and a hit reports no fill or eviction
    `RPTRR_ASSERT_IMPLY(a_hit_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[OBV_W-1:0] == '0) && (fill_req || (!ev_valid && fill_page == '0 && ev_page == '0)), "mapped result fields inconsistent")

    // frame zero is reserved and is never handed out on a miss
    `RPTRR_ASSERT_IMPLY(a_fill_frame, i_clk, i_rst_n, m_axis_tvalid && fill_req, frame != '0, "miss filled the reserved frame")

    `RPTRR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind rom_page_translation_round_robin_core rptrr_checker u_rptrr_checker (.*);

>>> tb/rom_page_translation_round_robin_core_checker.sv
// Checker for the ROM page translation core: predicts each request's translation and compares.
module rom_page_translation_round_robin_core_checker
    import rptrr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    input  logic                  i_s_ready,
    input  logic [S_DATA_W-1:0]   i_s_data,   // address
    input  logic [TYPE_W-1:0]     i_s_user,   // req_type
    input  logic                  i_m_valid,
    input  logic                  i_m_ready,
    // open_bus_value, fill_request, fill_page, frame, phys_addr, evicted_valid, evicted_page
    input  logic [M_DATA_W-1:0]   i_m_data,
    input  logic [0:0]            i_m_user,   // in_range
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [ROM_SIZE_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_open_bus,
    output int                    o_misses,
    output int                    o_evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_SHIFT  = 14;
    localparam int PAGE_COUNT  = 2048;
    localparam int FRAME_COUNT = 256;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic    in_range;
        t_result fields;
    } t_translation;

    t_translation           expected_translations[$];
    t_translation           head;
    t_translation           predicted;
    t_result                actual;

    logic                   page_valid [PAGE_COUNT];
    logic [FRAME_OUT_W-1:0] page_frame [PAGE_COUNT];
    logic                   frame_used [FRAME_COUNT];
    logic [PAGE_OUT_W-1:0]  frame_page [FRAME_COUNT];
    logic [FRAME_OUT_W-1:0] last_frame;
    logic [ROM_SIZE_W-1:0]  rom_size;

    int mismatches     = 0;
    int outstanding    = 0;
    int open_bus_reads = 0;
    int page_misses    = 0;
    int evictions      = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = outstanding;
    assign o_open_bus   = open_bus_reads;
    assign o_misses     = page_misses;
    assign o_evictions  = evictions;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, name, want, got);
            end
        end
    endtask

    function automatic t_translation translate_request(input t_req_type kind,
                                                       input logic [ADDR_W-1:0] addr);
        t_translation          r;
        logic [PAGE_OUT_W-1:0] page;
        logic [FRAME_OUT_W-1:0] victim;
        logic [31:0]           a32;
        r.in_range = 1'b0;
        r.fields   = '0;
        a32        = 32'(addr);
        if ({1'b0, addr} >= rom_size) begin
            open_bus_reads++;
            case (kind)
                REQ_BYTE: r.fields.open_bus_value = (a32 >> 1) & 32'hff;
                REQ_HALF: r.fields.open_bus_value = (a32 >> 1) & 32'hffff;
                default:  r.fields.open_bus_value = (((a32 >> 1) & 32'hffff) << 16)
                                                  | (((a32 + 32'd2) >> 1) & 32'hffff);
            endcase
            return r;
        end
        r.in_range = 1'b1;
        page = addr[ADDR_W-1:PAGE_SHIFT];
        if (!page_valid[page]) begin
            // round robin over frames 1..255, frame 0 stays with page 0
            victim = last_frame + 1'b1;
            if (victim == '0) begin
                victim = 1;
            end
            last_frame = victim;
            if (frame_used[victim]) begin
                page_valid[frame_page[victim]] = 1'b0;
                r.fields.ev_valid = 1'b1;
                r.fields.ev_page  = frame_page[victim];
                evictions++;
            end
            frame_used[victim]      = 1'b1;
            frame_page[victim]      = page;
            page_valid[page]        = 1'b1;
            page_frame[page]        = victim;
            r.fields.fill_request   = 1'b1;
            r.fields.fill_page      = page;
            page_misses++;
        end
        r.fields.frame     = page_frame[page];
        r.fields.phys_addr = {page_frame[page], addr[PAGE_SHIFT-1:0]};
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAGE_COUNT; i++) begin
                page_valid[i] = 1'b0;
                page_frame[i] = '0;
            end
            for (int i = 0; i < FRAME_COUNT; i++) begin
                frame_used[i] = 1'b0;
                frame_page[i] = '0;
            end
            page_valid[0] = 1'b1;
            frame_used[0] = 1'b1;
            last_frame    = '0;
            rom_size      = '0;
            expected_translations.delete();
            outstanding   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                rom_size = i_cfg_data;
            end
            if (i_m_valid && i_m_ready) begin
                actual = t_result'(i_m_data[RES_W-1:0]);
                if (expected_translations.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] result with no request outstanding: tuser %b tdata %h",
                                 $realtime, i_m_user, i_m_data);
                    end
                end else begin
                    head = expected_translations.pop_front();
                    outstanding--;
                    check_field("in_range", 32'(head.in_range), 32'(i_m_user[0]));
                    check_field("open_bus_value", head.fields.open_bus_value,
                                actual.open_bus_value);
                    check_field("fill_request", 32'(head.fields.fill_request),
                                32'(actual.fill_request));
                    check_field("fill_page", 32'(head.fields.fill_page), 32'(actual.fill_page));
                    check_field("frame", 32'(head.fields.frame), 32'(actual.frame));
                    check_field("phys_addr", 32'(head.fields.phys_addr), 32'(actual.phys_addr));
                    check_field("evicted_valid", 32'(head.fields.ev_valid),
                                32'(actual.ev_valid));
                    check_field("evicted_page", 32'(head.fields.ev_page), 32'(actual.ev_page));
                    check_field("tdata padding", 32'd0, 32'(i_m_data[M_DATA_W-1:RES_W]));
                end
            end
            if (i_s_valid && i_s_ready) begin
                predicted = translate_request(i_s_user, i_s_data[ADDR_W-1:0]);
                expected_translations.push_back(predicted);
                outstanding++;
            end
        end
    end

endmodule

>>> tb/rom_page_translation_round_robin_core_tb.sv
// Testbench top for the ROM page translation core: clock, reset, stimulus and verdict.
module rom_page_translation_round_robin_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rptrr_pkg::*;

    localparam t_req_type REQ_UNDEF = 2'd3;
    localparam logic [ROM_SIZE_W-1:0] ROM_FULL = 26'h2000000;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int IDLE_PERCENT   = 37;
    localparam int STEADY_FROM    = 320;
    localparam int STEADY_TO      = 470;
    localparam int HOLD_AT        = 600;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOT_PAGES      = 12;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [TYPE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [ROM_SIZE_W-1:0] i_cfg_data    = '0;

    int mismatches;
    int pending;
    int open_bus_reads;
    int page_misses;
    int evictions;

    int                    sent_count  = 0;
    int                    cfg_writes  = 0;
    int                    idle_cycles = 0;
    bit                    held        = 1'b0;
    logic [ROM_SIZE_W-1:0] rom_size_now = '0;
    logic [PAGE_OUT_W-1:0] hot_pages [HOT_PAGES];

    always #5 i_clk = ~i_clk;

    rom_page_translation_round_robin_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    rom_page_translation_round_robin_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_s_user     (s_axis_tuser),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_m_user     (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_open_bus   (open_bus_reads),
        .o_misses     (page_misses),
        .o_evictions  (evictions)
    );

    function automatic bit steady_stretch();
        return sent_count >= STEADY_FROM && sent_count < STEADY_TO;
    endfunction

    // often a small working set so pages hit, else any page, sometimes the ROM size edge
    function automatic logic [ADDR_W-1:0] pick_address();
        int                r;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        a = ADDR_W'($urandom);
        if (r < 40) begin
            a[ADDR_W-1:14] = hot_pages[$urandom_range(0, HOT_PAGES - 1)];
        end else if (r < 48 && rom_size_now != '0) begin
            a = ADDR_W'(rom_size_now - 1'b1 + ROM_SIZE_W'($urandom_range(0, 1)));
        end
        return a;
    endfunction

    // entered and left at a falling edge; tvalid stays high for a following request
    task automatic push_request(input t_req_type kind, input logic [ADDR_W-1:0] addr);
        while (!steady_stretch() && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'(addr);
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic write_rom_size(input logic [ROM_SIZE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid  <= 1'b0;
        rom_size_now  = value;
        cfg_writes++;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            push_request(t_req_type'($urandom_range(0, 3)), pick_address());
        end
    endtask

    // receiver: random stalls, one long hold-off to back up the core
    initial begin
        forever begin
            @(negedge i_clk);
            if (!held && sent_count >= HOLD_AT) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= steady_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("no request moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("** rom_page_translation_round_robin_core: FAILED **");
        $finish;
    end

    initial begin
        hot_pages[0] = '0;
        for (int i = 1; i < HOT_PAGES; i++) begin
            hot_pages[i] = PAGE_OUT_W'($urandom);
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // everything open bus
        write_rom_size('0);
        push_request(REQ_BYTE, 25'h0000000);
        push_request(REQ_HALF, 25'h1FFFFFF);
        push_request(REQ_WORD, 25'h001FFFF);
        push_request(REQ_UNDEF, 25'h1FFFFFF);
        push_request(REQ_WORD, 25'h0AAAAAA);
        push_request(REQ_BYTE, 25'h1555555);

        // whole space mapped: page zero, first misses and hits, top page
        write_rom_size(ROM_FULL);
        push_request(REQ_BYTE, 25'h0000000);
        push_request(REQ_HALF, 25'h0003FFF);
        push_request(REQ_WORD, 25'h0004000);
        push_request(REQ_BYTE, 25'h0007FFF);
        push_request(REQ_UNDEF, 25'h1FFFFFF);
        push_request(REQ_HALF, 25'h1FFC000);
        push_request(REQ_WORD, 25'h0AAAAAA);
        push_request(REQ_BYTE, 25'h1555555);

        // edge of the loaded size
        write_rom_size(26'h0010000);
        push_request(REQ_HALF, 25'h000FFFF);
        push_request(REQ_WORD, 25'h0010000);
        write_rom_size(26'd1);
        push_request(REQ_BYTE, 25'h0000000);
        push_request(REQ_BYTE, 25'h0000001);

        write_rom_size(ROM_SIZE_W'($urandom_range(1, 33554432)));
        run_random(250);
        write_rom_size(ROM_FULL);
        run_random(400);
        write_rom_size(ROM_SIZE_W'($urandom_range(2, 1 << 20)));
        run_random(150);

        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d requests under %0d ROM size settings", sent_count, cfg_writes);
        $display("open-bus reads %0d, page misses %0d, frames reclaimed %0d",
                 open_bus_reads, page_misses, evictions);
        if (mismatches == 0 && pending == 0) begin
            $display("** rom_page_translation_round_robin_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never returned", mismatches, pending);
            $display("** rom_page_translation_round_robin_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/rptrr_pkg.sv
sv/rptrr_ram.sv
sv/rom_page_translation_round_robin_core.sv
sv/rptrr_checker.sv
tb/rom_page_translation_round_robin_core_checker.sv
tb/rom_page_translation_round_robin_core_tb.sv
